[src/tccw_pkg.sv]
// ============================================================================
// tccw_pkg
// Shared types and constants of the text console cell writer: request and
// result payloads, cell codes, controller states and datapath commands.
// ============================================================================
package tccw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [1:0] ACT_PUT  = 2'd0;
    localparam logic [1:0] ACT_GOTO = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_SPACE     = 8'd32;
    localparam logic [7:0] RESET_ATTR     = 8'd15;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [6:0] column;
        logic [4:0] row;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_position;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attribute;
        logic             scrolled;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_WRITE_CHAR,
        ST_WRITE_CHAR_WRAP,
        ST_BLANK,
        ST_SCROLL_SETUP,
        ST_SCROLL_CLEAR,
        ST_WRITE_BS,
        ST_READ,
        ST_RESPOND
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_PUT_CHAR,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_GOTO,
        OP_READ_SETUP,
        OP_WRITE_ITEM,
        OP_WRITE_BS,
        OP_WRITE_BLANK,
        OP_SCROLL_SETUP,
        OP_READ
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_result;
    } tccw_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       is_newline;
        logic       is_backspace;
        logic       col_zero;
        logic       row_last;
        logic       wrap_scroll;
        logic       clear_done;
        logic       acc_col_last;
        logic       out_free;
    } tccw_status_t;

endpackage

[src/tccw_ctrl.sv]
// ============================================================================
// tccw_ctrl
// Controller of the text console cell writer: sequences the clearing pass,
// request decode, cell writes, scroll clears, reads and the result hand-off.
// ============================================================================
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  tccw_status_t status,
    output tccw_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (status.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (status.action)
                    ACT_PUT: begin
                        if (status.is_newline) begin
                            state_next = status.row_last ? ST_SCROLL_SETUP : ST_RESPOND;
                        end else if (status.is_backspace) begin
                            state_next = status.col_zero ? ST_RESPOND : ST_WRITE_BS;
                        end else begin
                            state_next = status.wrap_scroll ? ST_WRITE_CHAR_WRAP
                                                            : ST_WRITE_CHAR;
                        end
                    end
                    ACT_READ: state_next = ST_READ;
                    default:  state_next = ST_RESPOND;
                endcase
            end
            ST_WRITE_CHAR:      state_next = ST_BLANK;
            ST_WRITE_CHAR_WRAP: state_next = ST_SCROLL_SETUP;
            ST_BLANK:           state_next = ST_RESPOND;
            ST_SCROLL_SETUP:    state_next = ST_SCROLL_CLEAR;
            ST_SCROLL_CLEAR: begin
                if (status.acc_col_last) state_next = ST_RESPOND;
            end
            ST_WRITE_BS:        state_next = ST_RESPOND;
            ST_READ:            state_next = ST_RESPOND;
            ST_RESPOND: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default:            state_next = ST_INIT;
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        cmd.op          = OP_NONE;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_INIT: cmd.op = OP_CLEAR;
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_CAPTURE;
            end
            ST_DECODE: begin
                case (status.action)
                    ACT_PUT: begin
                        if (status.is_newline) begin
                            cmd.op = OP_NEWLINE;
                        end else if (status.is_backspace) begin
                            cmd.op = status.col_zero ? OP_NONE : OP_BACKSPACE;
                        end else begin
                            cmd.op = OP_PUT_CHAR;
                        end
                    end
                    ACT_GOTO: cmd.op = OP_GOTO;
                    ACT_READ: cmd.op = OP_READ_SETUP;
                    default:  cmd.op = OP_NONE;
                endcase
            end
            ST_WRITE_CHAR:      cmd.op = OP_WRITE_ITEM;
            ST_WRITE_CHAR_WRAP: cmd.op = OP_WRITE_ITEM;
            ST_BLANK:           cmd.op = OP_WRITE_BLANK;
            ST_SCROLL_SETUP:    cmd.op = OP_SCROLL_SETUP;
            ST_SCROLL_CLEAR:    cmd.op = OP_WRITE_BLANK;
            ST_WRITE_BS:        cmd.op = OP_WRITE_BS;
            ST_READ:            cmd.op = OP_READ;
            ST_RESPOND:         cmd.load_result = status.out_free;
            default:            cmd.op = OP_NONE;
        endcase
    end

endmodule

[src/tccw_datapath.sv]
// ============================================================================
// tccw_datapath
// Datapath of the text console cell writer: cursor, circular row base,
// screen memory, configuration register and result register.
// ============================================================================
module tccw_datapath
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  in_item_t     s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_data,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  tccw_cmd_t    cmd,
    output tccw_status_t status
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [ROW_W:0]    ROWS_EXT   = (ROW_W + 1)'(ROWS);
    localparam logic [6:0]        COL_IN_MAX = 7'(COLUMNS - 1);
    localparam logic [6:0]        ROW_IN_MAX = 7'(ROWS - 1);

    logic [CELL_W-1:0] mem [DEPTH];

    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic [7:0]        blank_attr_reg;
    logic              scroll_reg, scroll_next;
    logic              m_valid_reg, m_valid_next;
    logic [COL_W-1:0]  acc_col_reg, acc_col_next;
    logic [ROW_W-1:0]  acc_row_reg, acc_row_next;
    in_item_t          item_reg, item_next;
    logic [CELL_W-1:0] rd_data_reg;
    out_item_t         m_data_reg, m_data_next;

    logic [COL_W-1:0]  col_clamp;
    logic [ROW_W-1:0]  row_clamp;
    logic [ROW_W:0]    cur_sum, clamp_sum;
    logic [ROW_W-1:0]  cur_phys, clamp_phys;
    logic [ADDR_W-1:0] acc_addr;
    logic [ADDR_W-1:0] cursor_lin;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              out_free;

    assign col_clamp = (item_reg.column > COL_IN_MAX) ? COL_LAST : COL_W'(item_reg.column);
    assign row_clamp = ({2'b00, item_reg.row} > ROW_IN_MAX) ? ROW_LAST : ROW_W'(item_reg.row);

    assign cur_sum    = {1'b0, cursor_row_reg} + {1'b0, top_reg};
    assign cur_phys   = (cur_sum >= ROWS_EXT) ? ROW_W'(cur_sum - ROWS_EXT) : ROW_W'(cur_sum);
    assign clamp_sum  = {1'b0, row_clamp} + {1'b0, top_reg};
    assign clamp_phys = (clamp_sum >= ROWS_EXT) ? ROW_W'(clamp_sum - ROWS_EXT)
                                                : ROW_W'(clamp_sum);

    assign acc_addr   = ADDR_W'(acc_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(acc_col_reg);
    assign cursor_lin = ADDR_W'(cursor_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col_reg);

    assign out_free = !m_valid_reg || m_ready;

    assign status.action       = item_reg.action;
    assign status.is_newline   = (item_reg.char_code == CODE_NEWLINE);
    assign status.is_backspace = (item_reg.char_code == CODE_BACKSPACE);
    assign status.col_zero     = (cursor_col_reg == '0);
    assign status.row_last     = (cursor_row_reg == ROW_LAST);
    assign status.wrap_scroll  = (cursor_col_reg == COL_LAST) && (cursor_row_reg == ROW_LAST);
    assign status.clear_done   = (clear_cnt_reg == ADDR_LAST);
    assign status.acc_col_last = (acc_col_reg == COL_LAST);
    assign status.out_free     = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        top_next        = top_reg;
        clear_cnt_next  = clear_cnt_reg;
        scroll_next     = scroll_reg;
        acc_col_next    = acc_col_reg;
        acc_row_next    = acc_row_reg;
        item_next       = item_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = acc_addr;
        mem_wdata       = {blank_attr_reg, CODE_SPACE};
        case (cmd.op)
            OP_CLEAR: begin
                mem_we         = 1'b1;
                mem_waddr      = clear_cnt_reg;
                mem_wdata      = {RESET_ATTR, CODE_SPACE};
                clear_cnt_next = clear_cnt_reg + 1'b1;
            end
            OP_CAPTURE: begin
                item_next   = s_data;
                scroll_next = 1'b0;
            end
            OP_PUT_CHAR: begin
                acc_col_next = cursor_col_reg;
                acc_row_next = cur_phys;
                if (cursor_col_reg == COL_LAST) begin
                    cursor_col_next = '0;
                    if (cursor_row_reg != ROW_LAST) cursor_row_next = cursor_row_reg + 1'b1;
                end else begin
                    cursor_col_next = cursor_col_reg + 1'b1;
                end
            end
            OP_NEWLINE: begin
                cursor_col_next = '0;
                if (cursor_row_reg != ROW_LAST) cursor_row_next = cursor_row_reg + 1'b1;
            end
            OP_BACKSPACE: begin
                cursor_col_next = cursor_col_reg - 1'b1;
                acc_col_next    = cursor_col_reg - 1'b1;
                acc_row_next    = cur_phys;
            end
            OP_GOTO: begin
                cursor_col_next = col_clamp;
                cursor_row_next = row_clamp;
            end
            OP_READ_SETUP: begin
                acc_col_next = col_clamp;
                acc_row_next = clamp_phys;
            end
            OP_WRITE_ITEM: begin
                mem_we       = 1'b1;
                mem_wdata    = {item_reg.color, item_reg.char_code};
                acc_col_next = cursor_col_reg;
                acc_row_next = cur_phys;
            end
            OP_WRITE_BS: begin
                mem_we    = 1'b1;
                mem_wdata = {item_reg.color, CODE_SPACE};
            end
            OP_WRITE_BLANK: begin
                mem_we       = 1'b1;
                acc_col_next = acc_col_reg + 1'b1;
            end
            OP_SCROLL_SETUP: begin
                acc_col_next = '0;
                acc_row_next = top_reg;
                top_next     = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                scroll_next  = 1'b1;
            end
            OP_READ: mem_re = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        m_data_next                 = m_data_reg;
        m_valid_next                = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.load_result) begin
            m_valid_next                = 1'b1;
            m_data_next.cursor_position = POS_W'(cursor_lin);
            m_data_next.scrolled        = scroll_reg;
            if (item_reg.action == ACT_READ) begin
                m_data_next.cell_char      = rd_data_reg[7:0];
                m_data_next.cell_attribute = rd_data_reg[15:8];
            end else begin
                m_data_next.cell_char      = '0;
                m_data_next.cell_attribute = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            top_reg        <= '0;
            clear_cnt_reg  <= '0;
            blank_attr_reg <= RESET_ATTR;
            scroll_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            top_reg        <= top_next;
            clear_cnt_reg  <= clear_cnt_next;
            scroll_reg     <= scroll_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) blank_attr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        acc_col_reg <= acc_col_next;
        acc_row_reg <= acc_row_next;
        item_reg    <= item_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= mem[acc_addr];
    end

endmodule

[src/text_console_cell_writer_top.sv]
// ============================================================================
// text_console_cell_writer_top
// Character-cell text terminal: screen store, cursor, newline, backspace,
// scroll, goto and cell read behind a request/result stream pair.
// ============================================================================
// Requests enter on s_valid/s_ready with an in_item_t payload; every request
// returns exactly one out_item_t result on m_valid/m_ready. cfg_wr_en writes
// cfg_wr_data into the blank attribute register in the same cycle.
// Rows live in a circular buffer over the screen memory, so a scroll advances
// the top-row base and clears one row of COLUMNS cells, one cell a cycle,
// through the single write port of the memory.
// A request passes through decode to the result hand-off; a plain character
// also writes the character and then blanks the cell under the new cursor,
// a backspace off column zero writes a space, a read fetches the cell, and a
// scroll advances the top-row base and clears the new bottom row.
// Reset clears control state, then a clearing pass writes every cell to a
// space with attribute 0x0F, with s_ready low; configuration writes are
// taken during that pass.
// A finished result sits in an output register, and the next request is
// accepted while it waits; a stalled receiver holds the following result
// and blocks further requests until the register frees.
// ============================================================================
module text_console_cell_writer_top
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    tccw_cmd_t    cmd;
    tccw_status_t status;

    tccw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tccw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

[tb/sv/tccw_screen_checker.sv]
// ============================================================================
// tccw_screen_checker
// Watches both streams and the attribute register port of the text console
// cell writer. It keeps its own copy of the screen, the cursor and the blank
// attribute. Each accepted request updates that copy and queues the expected
// result. Each accepted result is compared field by field with the oldest
// queued one.
// ============================================================================
module tccw_screen_checker
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_item_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_item_t  m_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         mismatch_count,
    output int         pending_count,
    output int         results_checked,
    output int         scroll_count
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int PRINT_CAP  = 100;

    logic [CELL_W-1:0] screen_store [CELL_COUNT];
    int unsigned       cursor_col;
    int unsigned       cursor_row;
    logic [7:0]        blank_attr;
    out_item_t         expected_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP) begin
            $display("ERROR at %0t: %s got %0d, want %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic int unsigned saturate(input int unsigned v, input int unsigned lim);
        return (v > lim - 1) ? lim - 1 : v;
    endfunction

    function automatic void write_cell(input logic [7:0] ch, input logic [7:0] attr);
        screen_store[cursor_row * COLUMNS + cursor_col] = {attr, ch};
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen_store[i] = screen_store[i + COLUMNS];
        end
        for (int i = 0; i < COLUMNS; i++) begin
            screen_store[(ROWS - 1) * COLUMNS + i] = {blank_attr, CODE_SPACE};
        end
        cursor_row = ROWS - 1;
    endfunction

    function automatic out_item_t predict_console_result(input in_item_t req);
        out_item_t   res;
        int unsigned c;
        int unsigned r;
        res = '0;
        case (req.action)
            ACT_PUT: begin
                if (req.char_code == CODE_NEWLINE) begin
                    cursor_col = 0;
                    cursor_row++;
                    if (cursor_row >= ROWS) begin
                        scroll_screen();
                        res.scrolled = 1'b1;
                    end
                end else if (req.char_code == CODE_BACKSPACE) begin
                    if (cursor_col > 0) begin
                        cursor_col--;
                        write_cell(CODE_SPACE, req.color);
                    end
                end else begin
                    write_cell(req.char_code, req.color);
                    cursor_col++;
                    if (cursor_col >= COLUMNS) begin
                        cursor_col = 0;
                        cursor_row++;
                    end
                    if (cursor_row >= ROWS) begin
                        scroll_screen();
                        res.scrolled = 1'b1;
                    end
                    write_cell(CODE_SPACE, blank_attr);
                end
            end
            ACT_GOTO: begin
                cursor_col = saturate(32'(req.column), COLUMNS);
                cursor_row = saturate(32'(req.row), ROWS);
            end
            ACT_READ: begin
                c = saturate(32'(req.column), COLUMNS);
                r = saturate(32'(req.row), ROWS);
                {res.cell_attribute, res.cell_char} = screen_store[r * COLUMNS + c];
            end
            default: begin
            end
        endcase
        res.cursor_position = POS_W'(cursor_row * COLUMNS + cursor_col);
        if (res.scrolled) scroll_count++;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            foreach (screen_store[i]) screen_store[i] = {RESET_ATTR, CODE_SPACE};
            cursor_col = 0;
            cursor_row = 0;
            blank_attr = RESET_ATTR;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) blank_attr = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding, cursor_position",
                                    int'(m_data.cursor_position), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.cursor_position !== want.cursor_position)
                        report_mismatch("cursor_position", int'(m_data.cursor_position),
                                        int'(want.cursor_position));
                    if (m_data.cell_char !== want.cell_char)
                        report_mismatch("cell_char", int'(m_data.cell_char),
                                        int'(want.cell_char));
                    if (m_data.cell_attribute !== want.cell_attribute)
                        report_mismatch("cell_attribute", int'(m_data.cell_attribute),
                                        int'(want.cell_attribute));
                    if (m_data.scrolled !== want.scrolled)
                        report_mismatch("scrolled", int'(m_data.scrolled),
                                        int'(want.scrolled));
                    results_checked++;
                end
            end
            if (s_valid && s_ready) expected_results.push_back(predict_console_result(s_data));
        end
        pending_count <= expected_results.size();
    end

endmodule

[tb/sv/tb_top.sv]
// ============================================================================
// tb_top
// Stimulus and verdict for the text console cell writer. A directed run
// covers reset contents, edge cells, wrap, scroll, newline, backspace and
// saturation; three random phases follow under different idle patterns and
// blank attributes, one with a long receiver hold-off that backs up the block.
// ============================================================================
module tb_top;
    import tccw_pkg::*;

    localparam int         COLUMNS      = DEF_COLUMNS;
    localparam int         ROWS         = DEF_ROWS;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         HANG_LIMIT   = 10000;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 100;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_item_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_item_t  m_data;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    int mismatch_count;
    int pending_count;
    int results_checked;
    int scroll_count;

    int tx_idle_pct        = 17;
    int rx_stall_pct       = 47;
    int long_stalls_asked  = 0;
    int long_stalls_served = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;
    int requests_sent      = 0;
    int attr_settings      = 1;

    always #4 aclk = ~aclk;

    text_console_cell_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    tccw_screen_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .results_checked(results_checked),
        .scroll_count   (scroll_count)
    );

    // hold off for a long stretch when asked, else stall at random
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_stalls_served != long_stalls_asked) begin
            long_stalls_served <= long_stalls_asked;
            hold_left          <= LONG_HOLD;
            m_ready            <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == HANG_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", HANG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_item_t console_request(input logic [1:0] act, input logic [7:0] ch,
                                                 input logic [7:0] attr,
                                                 input logic [6:0] col,
                                                 input logic [4:0] row);
        return '{act, ch, attr, col, row};
    endfunction

    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic write_blank_attribute(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        attr_settings++;
    endtask

    task automatic run_random_phase(input int count, input bit with_long_stall);
        in_item_t req;
        int       pick;
        for (int n = 0; n < count; n++) begin
            if (with_long_stall && n == count / 2) long_stalls_asked <= long_stalls_asked + 1;
            req.char_code = 8'($urandom_range(255));
            req.color     = 8'($urandom_range(255));
            req.column    = 7'($urandom_range(127));
            req.row       = 5'($urandom_range(31));
            pick          = int'($urandom_range(99));
            if (pick < 55) begin
                req.action = ACT_PUT;
            end else if (pick < 63) begin
                req.action    = ACT_PUT;
                req.char_code = CODE_NEWLINE;
            end else if (pick < 71) begin
                req.action    = ACT_PUT;
                req.char_code = CODE_BACKSPACE;
            end else if (pick < 80) begin
                req.action = ACT_GOTO;
                // bias toward the bottom rows so scrolls stay frequent
                if (pick[0]) req.row = 5'($urandom_range(31, ROWS - 5));
            end else if (pick < 96) begin
                req.action = ACT_READ;
            end else begin
                req.action = ACT_UNUSED;
            end
            send_request(req);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(console_request(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
        send_request(console_request(ACT_READ, 8'hFF, 8'hFF, 7'd127, 5'd31));
        send_request(console_request(ACT_PUT, 8'h41, 8'h00, 7'd0, 5'd0));
        send_request(console_request(ACT_PUT, 8'hFF, 8'hFF, 7'd127, 5'd31));
        send_request(console_request(ACT_PUT, 8'h00, 8'h5A, 7'd0, 5'd0));
        send_request(console_request(ACT_PUT, CODE_BACKSPACE, 8'hA5, 7'd0, 5'd0));
        send_request(console_request(ACT_READ, 8'h00, 8'h00, 7'd2, 5'd0));
        send_request(console_request(ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0));
        send_request(console_request(ACT_PUT, CODE_NEWLINE, 8'h00, 7'd0, 5'd0));
        send_request(console_request(ACT_PUT, CODE_BACKSPACE, 8'h33, 7'd0, 5'd0));
        send_request(console_request(ACT_GOTO, 8'h00, 8'h00, 7'd127, 5'd31));
        send_request(console_request(ACT_PUT, 8'h5A, 8'h1E, 7'd0, 5'd0));
        send_request(console_request(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd23));
        send_request(console_request(ACT_READ, 8'h00, 8'h00, 7'd5, 5'd24));
        send_request(console_request(ACT_PUT, CODE_NEWLINE, 8'h00, 7'd0, 5'd0));
        send_request(console_request(ACT_GOTO, 8'h00, 8'h00, 7'd79, 5'd3));
        send_request(console_request(ACT_PUT, 8'h21, 8'h47, 7'd0, 5'd0));
        send_request(console_request(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd3));
        send_request(console_request(ACT_UNUSED, 8'hFF, 8'hFF, 7'd127, 5'd31));
        send_request(console_request(ACT_GOTO, 8'h00, 8'h00, 7'd100, 5'd7));
        send_request(console_request(ACT_GOTO, 8'h00, 8'h00, 7'd10, 5'd30));
        send_request(console_request(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
        wait_idle();

        write_blank_attribute(8'h00);
        run_random_phase(320, 1'b0);
        wait_idle();

        tx_idle_pct  <= 47;
        rx_stall_pct <= 17;
        write_blank_attribute(8'hFF);
        run_random_phase(320, 1'b0);
        wait_idle();

        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;
        write_blank_attribute(8'($urandom_range(255)));
        run_random_phase(310, 1'b1);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d requests under %0d blank attributes, %0d scrolls",
                 requests_sent, attr_settings, scroll_count);
        $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
